// ----- hdl/usmh_pkg.sv -----
package usmh_pkg;

  localparam int unsigned KeyW  = 8;
  localparam int unsigned HashW = 15;
  localparam int unsigned CfgW  = 16;
  // product of two hash-width words plus a key character
  localparam int unsigned ProdW = 2 * HashW + 1;

  localparam int unsigned MulCntW = $clog2(HashW);
  localparam int unsigned ModCntW = $clog2(ProdW);

  localparam logic [HashW-1:0] MultStart = 15'd31415;
  localparam logic [HashW-1:0] MultStep  = 15'd21783;

  localparam logic [CfgW-1:0] SizeReset    = 16'd1021;
  localparam logic [CfgW-1:0] MinTableSize = 16'd2;
  localparam logic [CfgW-1:0] MaxTableSize = 16'd32768;

  typedef enum logic [2:0] {
    StIdle,
    StMulA,
    StModA,
    StMulH,
    StModH
  } usmh_state_e;

endpackage

// ----- hdl/usmh_if.sv -----
interface usmh_key_if ();
  logic                         valid;
  logic                         ready;
  logic [usmh_pkg::KeyW-1:0]    key_char;

  modport source (output valid, output key_char, input ready);
  modport sink   (input valid, input key_char, output ready);
endinterface

interface usmh_hash_if ();
  logic                         valid;
  logic                         ready;
  logic [usmh_pkg::HashW-1:0]   hash_index;

  modport source (output valid, output hash_index, input ready);
  modport sink   (input valid, input hash_index, output ready);
endinterface

interface usmh_cfg_if ();
  logic                         valid;
  logic                         ready;
  logic [usmh_pkg::CfgW-1:0]    table_size;

  modport source (output valid, output table_size, input ready);
  modport sink   (input valid, input table_size, output ready);
endinterface

// ----- hdl/universal_string_hash.sv -----
// Universal string hash: key characters arrive one per transaction on key_i, a zero
// character ends the key and puts its table slot on hash_o, then the hash restarts.
// A zero character does not make the block busy. A nonzero character keeps it busy after
// its transaction, so the next character is taken only once that work is through. The
// work is done by one bit-serial shift-add multiplier and one bit-serial remainder unit,
// each used twice per character (multiplier update, then hash update), with a registered
// done strobe at each of the four handoffs. table_size must be written on cfg_i only
// while no character is in flight; the block itself does not enforce this. Values
// below 2 act as 2 and above 32768 act as 32768. A finished slot waits in an output
// register; while it waits no further character is taken until hash_o accepts the slot.
module universal_string_hash (
  input  logic           clk_i,
  input  logic           rst_ni,
  usmh_key_if.sink       key_i,
  usmh_cfg_if.sink       cfg_i,
  usmh_hash_if.source    hash_o
);

  usmh_pkg::usmh_state_e state_q, state_d;

  logic [usmh_pkg::CfgW-1:0]  size_q;
  logic [usmh_pkg::CfgW-1:0]  eff_size;
  logic [usmh_pkg::HashW-1:0] mult_q;
  logic [usmh_pkg::HashW-1:0] hash_q;
  logic [usmh_pkg::KeyW-1:0]  ch_q;
  logic [usmh_pkg::HashW-1:0] out_q;
  logic                       out_vld_q;

  logic                       key_fire;
  logic                       key_zero;
  logic                       mul_start, mul_done;
  logic                       mod_start, mod_done;
  logic [usmh_pkg::HashW-1:0] mul_mcand, mul_mplier;
  logic [usmh_pkg::KeyW-1:0]  mul_addend;
  logic [usmh_pkg::ProdW-1:0] mul_prod;
  logic [usmh_pkg::CfgW-1:0]  mod_modulus;
  logic [usmh_pkg::HashW-1:0] mod_rem;

  always_comb begin
    if (size_q < usmh_pkg::MinTableSize) begin
      eff_size = usmh_pkg::MinTableSize;
    end else if (size_q > usmh_pkg::MaxTableSize) begin
      eff_size = usmh_pkg::MaxTableSize;
    end else begin
      eff_size = size_q;
    end
  end

  assign key_fire = key_i.valid && key_i.ready;
  assign key_zero = (key_i.key_char == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      usmh_pkg::StIdle: begin
        if (key_fire && !key_zero) state_d = usmh_pkg::StMulA;
      end
      usmh_pkg::StMulA: begin
        if (mul_done) state_d = usmh_pkg::StModA;
      end
      usmh_pkg::StModA: begin
        if (mod_done) state_d = usmh_pkg::StMulH;
      end
      usmh_pkg::StMulH: begin
        if (mul_done) state_d = usmh_pkg::StModH;
      end
      usmh_pkg::StModH: begin
        if (mod_done) state_d = usmh_pkg::StIdle;
      end
      default: state_d = usmh_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    key_i.ready = 1'b0;
    mul_start   = 1'b0;
    mod_start   = 1'b0;
    mul_mcand   = usmh_pkg::MultStep;
    mul_mplier  = mult_q;
    mul_addend  = '0;
    mod_modulus = eff_size;
    case (state_q)
      usmh_pkg::StIdle: begin
        key_i.ready = !out_vld_q || hash_o.ready;
        mul_start   = key_fire && !key_zero;
      end
      usmh_pkg::StMulA: begin
        mod_start   = mul_done;
        mod_modulus = eff_size - 16'd1;
      end
      usmh_pkg::StModA: begin
        // new multiplier straight from the remainder unit
        mul_start  = mod_done;
        mul_mcand  = hash_q;
        mul_mplier = mod_rem;
        mul_addend = ch_q;
      end
      usmh_pkg::StMulH: begin
        mod_start = mul_done;
      end
      usmh_pkg::StModH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= usmh_pkg::StIdle;
      size_q    <= usmh_pkg::SizeReset;
      mult_q    <= usmh_pkg::MultStart;
      hash_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        size_q <= cfg_i.table_size;
      end
      if (key_fire && key_zero) begin
        mult_q    <= usmh_pkg::MultStart;
        hash_q    <= '0;
        out_vld_q <= 1'b1;
      end else begin
        if (hash_o.ready) out_vld_q <= 1'b0;
        if (state_q == usmh_pkg::StModA && mod_done) mult_q <= mod_rem;
        if (state_q == usmh_pkg::StModH && mod_done) hash_q <= mod_rem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_fire) begin
      ch_q <= key_i.key_char;
    end
    if (key_fire && key_zero) begin
      out_q <= hash_q;
    end
  end

  assign cfg_i.ready       = 1'b1;
  assign hash_o.valid      = out_vld_q;
  assign hash_o.hash_index = out_q;

  usmh_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .addend_i (mul_addend),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  usmh_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mul_prod),
    .modulus_i  (mod_modulus),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

endmodule

// ----- hdl/usmh_mul.sv -----
module usmh_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [usmh_pkg::HashW-1:0]    mcand_i,
  input  logic [usmh_pkg::HashW-1:0]    mplier_i,
  input  logic [usmh_pkg::KeyW-1:0]     addend_i,
  output logic                          done_o,
  output logic [usmh_pkg::ProdW-1:0]    prod_o
);

  localparam int unsigned HiW = usmh_pkg::ProdW - usmh_pkg::HashW;
  localparam logic [usmh_pkg::MulCntW-1:0] LastCnt = usmh_pkg::MulCntW'(usmh_pkg::HashW - 1);

  logic [usmh_pkg::ProdW-1:0]   acc_q, acc_d;
  logic [usmh_pkg::HashW-1:0]   mcand_q;
  logic [usmh_pkg::MulCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [HiW:0]                 sum;

  // right-shift multiplier, addend preloaded in the upper half comes out as a plain add
  always_comb begin
    sum = {1'b0, acc_q[usmh_pkg::ProdW-1:usmh_pkg::HashW]}
        + (acc_q[0] ? (HiW+1)'(mcand_q) : '0);
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = {(HiW)'(addend_i), mplier_i};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {sum, acc_q[usmh_pkg::HashW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      mcand_q <= mcand_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- hdl/usmh_mod.sv -----
module usmh_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [usmh_pkg::ProdW-1:0]    dividend_i,
  input  logic [usmh_pkg::CfgW-1:0]     modulus_i,
  output logic                          done_o,
  output logic [usmh_pkg::HashW-1:0]    rem_o
);

  localparam logic [usmh_pkg::ModCntW-1:0] LastCnt = usmh_pkg::ModCntW'(usmh_pkg::ProdW - 1);

  logic [usmh_pkg::ProdW-1:0]   sh_q, sh_d;
  logic [usmh_pkg::CfgW-1:0]    mod_q;
  logic [usmh_pkg::HashW-1:0]   rem_q, rem_d;
  logic [usmh_pkg::ModCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [usmh_pkg::CfgW-1:0]    trial;
  logic [usmh_pkg::CfgW-1:0]    diff;

  // restoring remainder, one dividend bit per cycle, msb first
  always_comb begin
    trial  = {rem_q, sh_q[usmh_pkg::ProdW-1]};
    diff   = trial - mod_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[usmh_pkg::ProdW-2:0], 1'b0};
      rem_d = (trial >= mod_q) ? diff[usmh_pkg::HashW-1:0] : trial[usmh_pkg::HashW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (start_i) begin
      mod_q <= modulus_i;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
